// ===== hdl/tlv_pkg.sv =====
// tlv_pkg: shared types, sizes and the key code table for the record indexer
// no dependencies; compiled first
`default_nettype none

package tlv_pkg;

  // sizes
  localparam int NUM_KEYS    = 16;
  localparam int OFFSET_BITS = 12;
  localparam int KEY_LIMIT   = (NUM_KEYS < 16) ? NUM_KEYS : 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // parser phase
  typedef enum logic [1:0] {
    PH_KEY  = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // result kinds
  typedef enum logic [2:0] {
    RK_RECORD  = 3'd0,
    RK_DONE    = 3'd1,
    RK_UNKNOWN = 3'd2,
    RK_DUP     = 3'd3,
    RK_OVERRUN = 3'd4
  } result_kind_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [3:0]   sensor_index;
    logic [7:0]   record_length;
    logic [11:0]  data_offset;
    logic [7:0]   bad_key;
    logic         end_of_run;
  } result_t;

  // fixed key codes, matched in index order
  function automatic logic [7:0] key_code(input logic [3:0] idx);
    logic [7:0] code;
    case (idx)
      4'd0:    code = 8'h21;
      4'd1:    code = 8'h22;
      4'd2:    code = 8'h23;
      4'd3:    code = 8'h24;
      4'd4:    code = 8'h25;
      4'd5:    code = 8'h26;
      4'd6:    code = 8'h27;
      4'd7:    code = 8'h28;
      4'd8:    code = 8'h29;
      4'd9:    code = 8'h2A;
      4'd10:   code = 8'h2B;
      4'd11:   code = 8'h4B;
      4'd12:   code = 8'h50;
      4'd13:   code = 8'h51;
      4'd14:   code = 8'h52;
      default: code = 8'h53;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tlv_if.sv =====
// tlv_byte_if / tlv_result_if: valid/ready channels for payload bytes and results
// no dependencies
`default_nettype none

interface tlv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface tlv_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [3:0]  sensor_index;
  logic [7:0]  record_length;
  logic [11:0] data_offset;
  logic [7:0]  bad_key;
  logic        end_of_run;

  modport source (output valid, output result_kind, output sensor_index,
                  output record_length, output data_offset, output bad_key,
                  output end_of_run, input ready);
  modport sink   (input valid, input result_kind, input sensor_index,
                  input record_length, input data_offset, input bad_key,
                  input end_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/tlv_record_indexer.sv =====
// tlv_record_indexer: key/length/data record parser with key match and result queue
// depends on tlv_pkg and the channel interfaces in tlv_if.sv
`default_nettype none

// channel     dir  modport  payload
// byte_in     in   sink     payload_byte[7:0], last_byte
// result_out  out  source   result_kind, sensor_index, record_length,
//                           data_offset, bad_key, end_of_run
//
// one byte per cycle while byte_in.ready is high: the key match and
// phase update sit between the parser registers and a four-entry result
// queue, and one transfer in writes zero, one or two results into the queue.
// results are registered into the queue and offered on result_out in order.
// byte_in.ready is high while the queue has room for two results (two or
// fewer pending), so a stalled output blocks input once three are pending.
// rst is synchronous and clears the parser state and the queue.

module tlv_record_indexer (
  input  wire logic         clk,
  input  wire logic         rst,
  tlv_byte_if.sink          byte_in,
  tlv_result_if.source      result_out
);

  localparam int OB = tlv_pkg::OFFSET_BITS;
  localparam int KL = tlv_pkg::KEY_LIMIT;
  localparam int QB = tlv_pkg::QPTR_BITS;

  // parser state
  tlv_pkg::phase_t  parse_phase, parse_phase_next;
  logic [7:0]       data_remaining, data_remaining_next;
  logic [KL-1:0]    keys_seen, keys_seen_next;
  logic [3:0]       current_sensor, current_sensor_next;
  logic [OB-1:0]    byte_offset, byte_offset_next;
  logic [OB-1:0]    record_start, record_start_next;
  logic [7:0]       record_len_held, record_len_held_next;
  logic             error_sticky, error_sticky_next;

  // result queue
  tlv_pkg::result_t queue_mem [tlv_pkg::QUEUE_DEPTH];
  logic [QB-1:0]    wr_ptr, rd_ptr;
  logic [QB:0]      count;

  logic             accept, pop;
  logic [1:0]       push_count;
  tlv_pkg::result_t res0, res1;

  // key match signals
  logic             key_found;
  logic [3:0]       key_idx;
  logic [7:0]       remaining_dec;

  assign accept = byte_in.valid & byte_in.ready;
  assign pop    = result_out.valid & result_out.ready;
  assign byte_in.ready = (count <= (QB+1)'(tlv_pkg::QUEUE_DEPTH - 2));

  // parallel key compare, lowest index wins
  always_comb begin
    key_found = 1'b0;
    key_idx   = 4'd0;
    for (int i = 0; i < KL; i++) begin
      if (!key_found && tlv_pkg::key_code(4'(i)) == byte_in.payload_byte) begin
        key_found = 1'b1;
        key_idx   = 4'(i);
      end
    end
  end

  assign remaining_dec = data_remaining - 8'd1;

  // phase and run state update, result build
  always_comb begin
    parse_phase_next     = parse_phase;
    data_remaining_next  = data_remaining;
    keys_seen_next       = keys_seen;
    current_sensor_next  = current_sensor;
    byte_offset_next     = byte_offset;
    record_start_next    = record_start;
    record_len_held_next = record_len_held;
    error_sticky_next    = error_sticky;
    push_count           = 2'd0;
    res0                 = '0;
    res1                 = '0;

    if (accept) begin
      if (!error_sticky) begin
        unique case (parse_phase)
          tlv_pkg::PH_LEN: begin
            record_len_held_next = byte_in.payload_byte;
            record_start_next    = byte_offset + OB'(1);
            if (byte_in.payload_byte == 8'd0) begin
              res0.result_kind   = tlv_pkg::RK_RECORD;
              res0.sensor_index  = current_sensor;
              res0.record_length = 8'd0;
              res0.data_offset   = 12'(byte_offset + OB'(1));
              parse_phase_next   = tlv_pkg::PH_KEY;
              push_count         = 2'd1;
              if (byte_in.last_byte) begin
                res1.result_kind = tlv_pkg::RK_DONE;
                res1.end_of_run  = 1'b1;
                push_count       = 2'd2;
              end
            end else if (byte_in.last_byte) begin
              res0.result_kind  = tlv_pkg::RK_OVERRUN;
              res0.end_of_run   = 1'b1;
              error_sticky_next = 1'b1;
              push_count        = 2'd1;
            end else begin
              data_remaining_next = byte_in.payload_byte;
              parse_phase_next    = tlv_pkg::PH_DATA;
            end
          end
          tlv_pkg::PH_DATA: begin
            data_remaining_next = remaining_dec;
            if (remaining_dec == 8'd0) begin
              res0.result_kind   = tlv_pkg::RK_RECORD;
              res0.sensor_index  = current_sensor;
              res0.record_length = record_len_held;
              res0.data_offset   = 12'(record_start);
              parse_phase_next   = tlv_pkg::PH_KEY;
              push_count         = 2'd1;
              if (byte_in.last_byte) begin
                res1.result_kind = tlv_pkg::RK_DONE;
                res1.end_of_run  = 1'b1;
                push_count       = 2'd2;
              end
            end else if (byte_in.last_byte) begin
              res0.result_kind  = tlv_pkg::RK_OVERRUN;
              res0.end_of_run   = 1'b1;
              error_sticky_next = 1'b1;
              push_count        = 2'd1;
            end
          end
          default: begin
            // expect key (the unused phase code lands here too)
            if (!key_found) begin
              res0.result_kind  = tlv_pkg::RK_UNKNOWN;
              res0.bad_key      = byte_in.payload_byte;
              res0.end_of_run   = byte_in.last_byte;
              error_sticky_next = 1'b1;
              push_count        = 2'd1;
            end else if (keys_seen[key_idx]) begin
              res0.result_kind  = tlv_pkg::RK_DUP;
              res0.sensor_index = key_idx;
              res0.bad_key      = byte_in.payload_byte;
              res0.end_of_run   = byte_in.last_byte;
              error_sticky_next = 1'b1;
              push_count        = 2'd1;
            end else begin
              keys_seen_next[key_idx] = 1'b1;
              current_sensor_next = key_idx;
              if (byte_in.last_byte) begin
                res0.result_kind  = tlv_pkg::RK_OVERRUN;
                res0.end_of_run   = 1'b1;
                error_sticky_next = 1'b1;
                push_count        = 2'd1;
              end else begin
                parse_phase_next = tlv_pkg::PH_LEN;
              end
            end
          end
        endcase
      end

      byte_offset_next = byte_offset + OB'(1);

      // end of run returns all run state to its reset value
      if (byte_in.last_byte) begin
        parse_phase_next     = tlv_pkg::PH_KEY;
        data_remaining_next  = 8'd0;
        keys_seen_next       = '0;
        current_sensor_next  = 4'd0;
        byte_offset_next     = '0;
        record_start_next    = '0;
        record_len_held_next = 8'd0;
        error_sticky_next    = 1'b0;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= tlv_pkg::PH_KEY;
      data_remaining  <= 8'd0;
      keys_seen       <= '0;
      current_sensor  <= 4'd0;
      byte_offset     <= '0;
      record_start    <= '0;
      record_len_held <= 8'd0;
      error_sticky    <= 1'b0;
    end else begin
      parse_phase     <= parse_phase_next;
      data_remaining  <= data_remaining_next;
      keys_seen       <= keys_seen_next;
      current_sensor  <= current_sensor_next;
      byte_offset     <= byte_offset_next;
      record_start    <= record_start_next;
      record_len_held <= record_len_held_next;
      error_sticky    <= error_sticky_next;
    end
  end

  // queue storage, up to two writes per transfer in
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      queue_mem[wr_ptr] <= res0;
    end
    if (push_count == 2'd2) begin
      queue_mem[wr_ptr + QB'(1)] <= res1;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QB'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + QB'(1);
      end
      count <= count + (QB+1)'(push_count) - (QB+1)'(pop);
    end
  end

  // output side
  assign result_out.valid         = (count != '0);
  assign result_out.result_kind   = queue_mem[rd_ptr].result_kind;
  assign result_out.sensor_index  = queue_mem[rd_ptr].sensor_index;
  assign result_out.record_length = queue_mem[rd_ptr].record_length;
  assign result_out.data_offset   = queue_mem[rd_ptr].data_offset;
  assign result_out.bad_key       = queue_mem[rd_ptr].bad_key;
  assign result_out.end_of_run    = queue_mem[rd_ptr].end_of_run;

endmodule

`default_nettype wire
